/* src/dtw_pkg.sv */
package dtw_pkg;

    localparam int MAX_LEN      = 1024;
    localparam int SAMPLE_WIDTH = 16;
    localparam int IDX_W        = $clog2(MAX_LEN);
    localparam int LEN_W        = $clog2(MAX_LEN + 1);
    localparam int DIST_W       = 32;
    localparam int COST_W       = SAMPLE_WIDTH + 1;
    localparam int STATUS_W     = 2;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic OP_REF   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_REF    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TRUNCATED = 2'd2;

    typedef struct packed {
        logic first_row;
        logic first_col;
    } t_cell_ctl;

endpackage

/* src/dtw_ram.sv */
module dtw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/dtw_cell.sv */
module dtw_cell (
    input  logic signed [dtw_pkg::SAMPLE_WIDTH-1:0] i_query,
    input  logic signed [dtw_pkg::SAMPLE_WIDTH-1:0] i_ref,
    input  logic        [dtw_pkg::DIST_W-1:0]       i_top,
    input  logic        [dtw_pkg::DIST_W-1:0]       i_left,
    input  logic        [dtw_pkg::DIST_W-1:0]       i_diag,
    input  dtw_pkg::t_cell_ctl                      i_ctl,
    output logic        [dtw_pkg::DIST_W-1:0]       o_cell
);
    import dtw_pkg::*;

    logic signed [COST_W-1:0] diff;
    logic        [COST_W-1:0] cost;
    logic        [DIST_W-1:0] min_tl;
    logic        [DIST_W-1:0] best;
    logic        [DIST_W:0]   sum;

    always_comb begin
        diff   = COST_W'(i_query) - COST_W'(i_ref);
        cost   = diff[COST_W-1] ? COST_W'(-diff) : COST_W'(diff);
        min_tl = (i_top < i_left) ? i_top : i_left;
        if (i_ctl.first_row) begin
            best = i_ctl.first_col ? '0 : i_left;
        end else if (i_ctl.first_col) begin
            best = i_top;
        end else begin
            best = (min_tl < i_diag) ? min_tl : i_diag;
        end
        sum    = {1'b0, best} + (DIST_W + 1)'(cost);
        o_cell = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
    end

endmodule

/* src/dtw_distance_engine.sv */
// Dynamic time warping distance engine with absolute-difference cost. Send reference samples
// with tuser = 0 (tlast on the final one), then query samples with tuser = 1; the distance is
// returned after the query sample marked tlast. Each query sample walks the row buffer RAM one
// cell per cycle, reading and writing back one entry each cycle; no new sample is accepted
// until the walk ends. The final query sample then passes its result through the emit state
// into the output register, which frees the input side while the result waits there. At most
// 1024 reference samples are kept; further ones are dropped and flagged.
module dtw_distance_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [dtw_pkg::SAMPLE_WIDTH-1:0]  i_s_axis_tdata,  // sample
    input  logic                              i_s_axis_tuser,  // opcode
    input  logic                              i_s_axis_tlast,  // last
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [dtw_pkg::DIST_W-1:0]        o_m_axis_tdata,  // distance
    output logic [dtw_pkg::STATUS_W:0]        o_m_axis_tuser   // status [1:0], saturated [2]
);
    import dtw_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT
    } t_state;

    t_state                  r_state, n_state;
    logic [LEN_W-1:0]        r_ref_len, n_ref_len;
    logic                    r_ref_done, n_ref_done;
    logic                    r_trunc, n_trunc;
    logic                    r_first_row, n_first_row;
    logic [IDX_W-1:0]        r_j, n_j;
    logic [DIST_W-1:0]       r_left, n_left;
    logic [DIST_W-1:0]       r_diag, n_diag;
    logic [SAMPLE_WIDTH-1:0] r_query, n_query;
    logic                    r_last, n_last;
    logic [DIST_W-1:0]       r_emit_dist, n_emit_dist;
    logic [STATUS_W-1:0]     r_emit_status, n_emit_status;
    logic                    r_out_valid, n_out_valid;
    logic [DIST_W-1:0]       r_out_dist, n_out_dist;
    logic [STATUS_W-1:0]     r_out_status, n_out_status;
    logic                    r_out_sat, n_out_sat;

    logic                    in_acc;
    logic [LEN_W-1:0]        base_len;
    logic                    ref_we;
    logic [IDX_W-1:0]        ref_waddr;
    logic                    row_we;
    logic [IDX_W-1:0]        rd_addr;
    logic [SAMPLE_WIDTH-1:0] ref_rd;
    logic [DIST_W-1:0]       row_rd;
    logic [DIST_W-1:0]       cell_out;
    t_cell_ctl               cell_ctl;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign base_len        = r_ref_done ? '0 : r_ref_len;
    assign rd_addr         = (r_state == ST_WALK) ? IDX_W'(r_j + 1'b1) : '0;
    assign cell_ctl        = '{first_row: r_first_row, first_col: (r_j == '0)};

    dtw_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(MAX_LEN)) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (ref_we),
        .i_waddr (ref_waddr),
        .i_wdata (i_s_axis_tdata),
        .i_raddr (rd_addr),
        .o_rdata (ref_rd)
    );

    dtw_ram #(.WIDTH(DIST_W), .DEPTH(MAX_LEN)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (r_j),
        .i_wdata (cell_out),
        .i_raddr (rd_addr),
        .o_rdata (row_rd)
    );

    dtw_cell u_cell (
        .i_query (r_query),
        .i_ref   (ref_rd),
        .i_top   (row_rd),
        .i_left  (r_left),
        .i_diag  (r_diag),
        .i_ctl   (cell_ctl),
        .o_cell  (cell_out)
    );

    always_comb begin
        n_state       = r_state;
        n_ref_len     = r_ref_len;
        n_ref_done    = r_ref_done;
        n_trunc       = r_trunc;
        n_first_row   = r_first_row;
        n_j           = r_j;
        n_left        = r_left;
        n_diag        = r_diag;
        n_query       = r_query;
        n_last        = r_last;
        n_emit_dist   = r_emit_dist;
        n_emit_status = r_emit_status;
        n_out_valid   = r_out_valid && !i_m_axis_tready;
        n_out_dist    = r_out_dist;
        n_out_status  = r_out_status;
        n_out_sat     = r_out_sat;
        ref_we        = 1'b0;
        ref_waddr     = base_len[IDX_W-1:0];
        row_we        = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_s_axis_tuser == OP_REF) begin
                        if (r_ref_done) begin
                            n_ref_done  = 1'b0;
                            n_trunc     = 1'b0;
                            n_first_row = 1'b1;
                        end
                        n_ref_len = base_len;
                        if (base_len < LEN_W'(MAX_LEN)) begin
                            ref_we    = 1'b1;
                            n_ref_len = base_len + 1'b1;
                        end else begin
                            n_trunc = 1'b1;
                        end
                        if (i_s_axis_tlast) begin
                            n_ref_done = 1'b1;
                        end
                    end else if (r_ref_len == '0) begin
                        if (i_s_axis_tlast) begin
                            n_emit_dist   = '0;
                            n_emit_status = STATUS_NO_REF;
                            n_first_row   = 1'b1;
                            n_state       = ST_EMIT;
                        end
                    end else begin
                        n_ref_done = 1'b1;
                        n_query    = i_s_axis_tdata;
                        n_last     = i_s_axis_tlast;
                        n_j        = '0;
                        n_state    = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                row_we = 1'b1;
                n_left = cell_out;
                n_diag = row_rd;
                n_j    = IDX_W'(r_j + 1'b1);
                if ({1'b0, r_j} == LEN_W'(r_ref_len - 1'b1)) begin
                    n_first_row = r_last;
                    if (r_last) begin
                        n_emit_dist   = cell_out;
                        n_emit_status = r_trunc ? STATUS_TRUNCATED : STATUS_OK;
                        n_state       = ST_EMIT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_dist   = r_emit_dist;
                    n_out_status = r_emit_status;
                    n_out_sat    = (r_emit_dist == DIST_MAX);
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ref_len   <= '0;
            r_ref_done  <= 1'b0;
            r_trunc     <= 1'b0;
            r_first_row <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ref_len   <= n_ref_len;
            r_ref_done  <= n_ref_done;
            r_trunc     <= n_trunc;
            r_first_row <= n_first_row;
            r_out_valid <= n_out_valid;
        end
        r_j           <= n_j;
        r_left        <= n_left;
        r_diag        <= n_diag;
        r_query       <= n_query;
        r_last        <= n_last;
        r_emit_dist   <= n_emit_dist;
        r_emit_status <= n_emit_status;
        r_out_dist    <= n_out_dist;
        r_out_status  <= n_out_status;
        r_out_sat     <= n_out_sat;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_dist;
    assign o_m_axis_tuser  = {r_out_sat, r_out_status};

    a_walk_has_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_ref_len != '0))
        else $error("row walk running with an empty reference");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> ({1'b0, r_j} < r_ref_len))
        else $error("row walk index beyond the reference length");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ref_len <= LEN_W'(MAX_LEN))
        else $error("reference length above capacity");

    a_trunc_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trunc |-> (r_ref_len == LEN_W'(MAX_LEN)))
        else $error("truncation flagged before the store is full");

    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_out_valid && !i_m_axis_tready) |=> (r_state == ST_EMIT))
        else $error("pending result dropped while the output was stalled");

endmodule

/* verif/dtw_distance_engine_tb.sv */
module dtw_distance_engine_tb;
    import dtw_pkg::*;

    typedef struct packed {
        logic [DIST_W-1:0]   distance;
        logic [STATUS_W-1:0] status;
        logic                saturated;
    } t_dtw_result;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [SAMPLE_WIDTH-1:0] s_tdata;
    logic                    s_tuser;
    logic                    s_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [DIST_W-1:0]       m_tdata;
    logic [STATUS_W:0]       m_tuser;

    longint            ref_samples [MAX_LEN];
    logic [DIST_W-1:0] row_cells [MAX_LEN];
    int                ref_len;
    bit                ref_done;
    bit                ref_trunc;
    bit                first_row;

    t_dtw_result pending_results[$];
    int          mismatches;
    int          items_sent;
    int          burst_left;

    dtw_distance_engine u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // Updates one row of the warping recurrence, or the stored reference, per item.
    function automatic void update_warp_row(logic op, logic [SAMPLE_WIDTH-1:0] raw, logic lst);
        longint            smp;
        longint            diff;
        logic [DIST_W-1:0] top;
        logic [DIST_W-1:0] best;
        logic [DIST_W-1:0] diag;
        logic [DIST_W:0]   sum;
        t_dtw_result       res;
        smp = $signed(raw);
        if (op == OP_REF) begin
            if (ref_done) begin
                ref_len   = 0;
                ref_done  = 1'b0;
                ref_trunc = 1'b0;
                first_row = 1'b1;
            end
            if (ref_len < MAX_LEN) begin
                ref_samples[ref_len] = smp;
                ref_len++;
            end else begin
                ref_trunc = 1'b1;
            end
            if (lst) begin
                ref_done = 1'b1;
            end
            return;
        end
        if (ref_len == 0) begin
            if (lst) begin
                res.distance  = '0;
                res.status    = STATUS_NO_REF;
                res.saturated = 1'b0;
                pending_results.push_back(res);
                first_row = 1'b1;
            end
            return;
        end
        ref_done = 1'b1;
        diag = '0;
        for (int j = 0; j < ref_len; j++) begin
            diff = smp - ref_samples[j];
            if (diff < 0) begin
                diff = -diff;
            end
            top = row_cells[j];
            if (first_row) begin
                best = (j == 0) ? '0 : row_cells[j-1];
            end else if (j == 0) begin
                best = top;
            end else begin
                best = top;
                if (row_cells[j-1] < best) begin
                    best = row_cells[j-1];
                end
                if (diag < best) begin
                    best = diag;
                end
            end
            diag = top;
            sum = {1'b0, best} + diff[DIST_W:0];
            row_cells[j] = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
        end
        first_row = 1'b0;
        if (lst) begin
            res.distance  = row_cells[ref_len-1];
            res.status    = ref_trunc ? STATUS_TRUNCATED : STATUS_OK;
            res.saturated = (res.distance == DIST_MAX);
            pending_results.push_back(res);
            first_row = 1'b1;
        end
    endfunction

    function automatic void note_mismatch(string what, longint want, longint got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
        end
    endfunction

    always @(posedge clk) begin : check_results
        t_dtw_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result, distance", -1, m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.distance) begin
                    note_mismatch("distance", want.distance, m_tdata);
                end
                if (m_tuser[STATUS_W-1:0] !== want.status) begin
                    note_mismatch("status", want.status, m_tuser[STATUS_W-1:0]);
                end
                if (m_tuser[STATUS_W] !== want.saturated) begin
                    note_mismatch("saturated", want.saturated, m_tuser[STATUS_W]);
                end
            end
        end
    end

    initial begin : receiver_pattern
        int mode;
        int left;
        m_tready = 1'b1;
        mode = 0;
        left = 0;
        forever begin
            @(negedge clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 300);
            end
            left--;
            case (mode)
                0: begin
                    m_tready = 1'b1;
                end
                1: begin
                    m_tready = 1'($urandom_range(0, 1));
                end
                2: begin
                    m_tready = ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_tready = ((left % 8) < 5);
                end
            endcase
        end
    end

    task automatic send_item(logic op, logic [SAMPLE_WIDTH-1:0] smp, logic lst);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 6);
            end
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = smp;
        s_tlast  = lst;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        update_warp_row(op, smp, lst);
        items_sent++;
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
        logic [SAMPLE_WIDTH-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                v = 16'h8000;
            end
            1: begin
                v = 16'h7fff;
            end
            2, 3: begin
                v = SAMPLE_WIDTH'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
            default: begin
                v = SAMPLE_WIDTH'($urandom);
            end
        endcase
        return v;
    endfunction

    task automatic test_no_reference();
        send_item(OP_QUERY, 16'h1234, 1'b0);
        send_item(OP_QUERY, 16'h8000, 1'b1);
        send_item(OP_QUERY, 16'h7fff, 1'b1);
        wait_results_drained();
    endtask

    task automatic test_sample_extremes();
        send_item(OP_REF, 16'h8000, 1'b0);
        send_item(OP_REF, 16'h7fff, 1'b0);
        send_item(OP_REF, 16'h0000, 1'b0);
        send_item(OP_REF, 16'hffff, 1'b1);
        send_item(OP_QUERY, 16'h7fff, 1'b0);
        send_item(OP_QUERY, 16'h8000, 1'b0);
        send_item(OP_QUERY, 16'h0001, 1'b1);
        send_item(OP_QUERY, 16'h0000, 1'b1);
        wait_results_drained();
    endtask

    task automatic test_open_reference();
        send_item(OP_REF, 16'h0100, 1'b0);
        send_item(OP_REF, 16'hff00, 1'b0);
        send_item(OP_QUERY, 16'h0080, 1'b1);
        send_item(OP_REF, 16'h0005, 1'b1);
        send_item(OP_QUERY, 16'h0005, 1'b1);
        wait_results_drained();
    endtask

    task automatic test_query_discarded();
        send_item(OP_REF, 16'h0010, 1'b0);
        send_item(OP_REF, 16'h0020, 1'b1);
        send_item(OP_QUERY, 16'h0030, 1'b0);
        send_item(OP_QUERY, 16'h0040, 1'b0);
        send_item(OP_REF, 16'h7fff, 1'b1);
        send_item(OP_QUERY, 16'h8000, 1'b1);
        wait_results_drained();
    endtask

    // Exactly full, then overflowing, then a short reference that clears the flag.
    task automatic test_capacity();
        for (int i = 0; i < MAX_LEN; i++) begin
            send_item(OP_REF, pick_sample(), i == MAX_LEN - 1);
        end
        send_item(OP_QUERY, pick_sample(), 1'b0);
        send_item(OP_QUERY, pick_sample(), 1'b1);
        wait_results_drained();
        for (int i = 0; i < MAX_LEN + 2; i++) begin
            send_item(OP_REF, pick_sample(), i == MAX_LEN + 1);
        end
        send_item(OP_QUERY, pick_sample(), 1'b0);
        send_item(OP_QUERY, pick_sample(), 1'b1);
        send_item(OP_QUERY, pick_sample(), 1'b1);
        wait_results_drained();
        send_item(OP_REF, pick_sample(), 1'b0);
        send_item(OP_REF, pick_sample(), 1'b1);
        send_item(OP_QUERY, pick_sample(), 1'b0);
        send_item(OP_QUERY, pick_sample(), 1'b1);
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int  start;
        int  pick;
        int  rlen;
        int  nq;
        int  qlen;
        bit  open_ref;
        bit  cut;
        start = items_sent;
        while (items_sent - start < 580) begin
            pick = $urandom_range(0, 19);
            if (pick < 16) begin
                rlen = $urandom_range(1, 16);
            end else if (pick < 19) begin
                rlen = $urandom_range(17, 64);
            end else begin
                rlen = $urandom_range(65, 160);
            end
            open_ref = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < rlen; i++) begin
                send_item(OP_REF, pick_sample(), (i == rlen - 1) && !open_ref);
            end
            nq = $urandom_range(1, 3);
            for (int q = 0; q < nq; q++) begin
                qlen = $urandom_range(1, 12);
                cut = ($urandom_range(0, 9) == 0);
                for (int i = 0; i < qlen; i++) begin
                    send_item(OP_QUERY, pick_sample(), (i == qlen - 1) && !cut);
                end
                if (cut) begin
                    break;
                end
            end
        end
        wait_results_drained();
    endtask

    initial begin
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = OP_REF;
        s_tlast    = 1'b0;
        rst_n      = 1'b0;
        mismatches = 0;
        items_sent = 0;
        burst_left = 0;
        ref_len    = 0;
        ref_done   = 1'b0;
        ref_trunc  = 1'b0;
        first_row  = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_no_reference();
        test_sample_extremes();
        test_open_reference();
        test_query_discarded();
        test_capacity();
        test_random_traffic();

        repeat (2 * MAX_LEN) @(posedge clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
